>>> rtl/core/dpb_pkg.sv
// Shared types, widths and constants for the depth pixel back-projection block.
`default_nettype none

package dpb_pkg;

  // Field widths of the transactions
  localparam int COL_W     = 12;
  localparam int DEPTH_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int CFG_W     = 16;
  localparam int PT_W      = 24;
  localparam int CFG_IDX_W = 3;

  // Quotient bits: one above the point width flags overflow
  localparam int QUO_W = PT_W + 1;

  // Saturation limits of a point coordinate
  localparam logic [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

  // Register reset values
  localparam logic [CFG_W-1:0] RST_FOCAL_X     = 16'd9600;
  localparam logic [CFG_W-1:0] RST_FOCAL_Y     = 16'd9600;
  localparam logic [CFG_W-1:0] RST_CENTER_X    = 16'd5120;
  localparam logic [CFG_W-1:0] RST_CENTER_Y    = 16'd3840;
  localparam logic [CFG_W-1:0] RST_DEPTH_LIMIT = 16'd3000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X     = 3'd0,
    CFG_FOCAL_Y     = 3'd1,
    CFG_CENTER_X    = 3'd2,
    CFG_CENTER_Y    = 3'd3,
    CFG_DEPTH_LIMIT = 3'd4
  } cfg_idx_t;

  // Input transaction
  typedef struct packed {
    logic [COL_W-1:0]   pixel_column;
    logic [COL_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_mm;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } in_pixel_t;

  // Result transaction
  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [DEPTH_W-1:0]     point_z;
    logic [COLOR_W-1:0]     red_out;
    logic [COLOR_W-1:0]     green_out;
    logic [COLOR_W-1:0]     blue_out;
  } out_point_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [DEPTH_W-1:0] point_z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } side_t;

  // Per-axis control flags that travel with the quotient
  typedef struct packed {
    logic neg;
    logic den_zero;
    logic num_zero;
  } axis_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/depth_pixel_backprojection_top.sv
// A kept pixel goes through the front stages, quotient stages and output register.
// Throughput: one pixel per cycle; the 25-stage quotient pipeline, one bit per stage
// for each axis, sets the depth, and a stalled output holds the whole pipeline.
// Pixels with zero depth or depth at or above the limit give no result.
// Reset (synchronous, active low) empties the pipeline and restores the registers.
`default_nettype none

module depth_pixel_backprojection_top
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_pixel_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_point_t                out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PIX_W = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam int DW    = (PIX_W + 4 > CFG_W) ? PIX_W + 4 : CFG_W;
  localparam int NUM_W = DW + DEPTH_BITS + 6;

  logic [CFG_W-1:0] focal_x_r;
  logic [CFG_W-1:0] focal_y_r;
  logic [CFG_W-1:0] center_x_r;
  logic [CFG_W-1:0] center_y_r;
  logic [CFG_W-1:0] depth_limit_r;

  logic             adv;
  logic             fr_valid;
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_y;
  axis_flags_t      flags_x;
  axis_flags_t      flags_y;
  side_t            fr_side;
  logic             div_v;
  out_point_t       div_point;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r     <= RST_FOCAL_X;
      focal_y_r     <= RST_FOCAL_Y;
      center_x_r    <= RST_CENTER_X;
      center_y_r    <= RST_CENTER_Y;
      depth_limit_r <= RST_DEPTH_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FOCAL_X:     focal_x_r     <= cfg_wdata;
        CFG_FOCAL_Y:     focal_y_r     <= cfg_wdata;
        CFG_CENTER_X:    center_x_r    <= cfg_wdata;
        CFG_CENTER_Y:    center_y_r    <= cfg_wdata;
        CFG_DEPTH_LIMIT: depth_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = adv;

  dpb_front #(
    .PIX_W (PIX_W),
    .DB    (DEPTH_BITS),
    .DW    (DW),
    .NUM_W (NUM_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .focal_x     (focal_x_r),
    .focal_y     (focal_y_r),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .depth_limit (depth_limit_r),
    .fr_valid    (fr_valid),
    .num_x       (num_x),
    .num_y       (num_y),
    .flags_x     (flags_x),
    .flags_y     (flags_y),
    .fr_side     (fr_side)
  );

  // Divisor is twice the focal length for rounding to nearest
  dpb_div_pipe #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_v      (fr_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .den_x     ({focal_x_r, 1'b0}),
    .den_y     ({focal_y_r, 1'b0}),
    .flags_x   (flags_x),
    .flags_y   (flags_y),
    .side_in   (fr_side),
    .out_v     (div_v),
    .out_point (div_point)
  );

  dpb_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_v    (div_v),
    .pipe_data (div_point),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/dpb_front.sv
// Front stages: depth filter, centered offset, depth product and rounding numerator.
`default_nettype none

module dpb_front
  import dpb_pkg::*;
#(
  parameter int PIX_W = 12,
  parameter int DB    = 16,
  parameter int DW    = 16,
  parameter int NUM_W = 38
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire in_pixel_t        in_data,
  input  wire logic [CFG_W-1:0] focal_x,
  input  wire logic [CFG_W-1:0] focal_y,
  input  wire logic [CFG_W-1:0] center_x,
  input  wire logic [CFG_W-1:0] center_y,
  input  wire logic [CFG_W-1:0] depth_limit,
  output logic                  fr_valid,
  output logic [NUM_W-1:0]      num_x,
  output logic [NUM_W-1:0]      num_y,
  output axis_flags_t           flags_x,
  output axis_flags_t           flags_y,
  output side_t                 fr_side
);

  localparam int PW = DW + DB;

  // Stage 1 signals
  logic [PIX_W-1:0] col;
  logic [PIX_W-1:0] row;
  logic [DB-1:0]    d;
  logic             keep;
  logic signed [DW:0] diff_x;
  logic signed [DW:0] diff_y;
  logic [DW:0]      negd_x;
  logic [DW:0]      negd_y;

  logic             v1_r;
  logic [DW-1:0]    absd_x_r;
  logic [DW-1:0]    absd_y_r;
  logic             neg_x1_r;
  logic             neg_y1_r;
  logic [DB-1:0]    d1_r;
  side_t            side1_r;

  // Stage 2 signals
  logic             v2_r;
  logic [PW-1:0]    prod_x_r;
  logic [PW-1:0]    prod_y_r;
  logic             neg_x2_r;
  logic             neg_y2_r;
  side_t            side2_r;

  // Stage 3 signals
  logic             v3_r;
  logic [NUM_W-1:0] num_x_r;
  logic [NUM_W-1:0] num_y_r;
  axis_flags_t      flags_x_r;
  axis_flags_t      flags_y_r;
  side_t            side3_r;

  // Mask the fields and take the pixel index as Q.4 against the principal point
  assign col  = in_data.pixel_column[PIX_W-1:0];
  assign row  = in_data.pixel_row[PIX_W-1:0];
  assign d    = in_data.depth_mm[DB-1:0];
  assign keep = (d != '0) && (DEPTH_W'(d) < depth_limit);

  assign diff_x = $signed({1'b0, DW'({col, 4'b0000})}) - $signed({1'b0, DW'(center_x)});
  assign diff_y = $signed({1'b0, DW'({row, 4'b0000})}) - $signed({1'b0, DW'(center_y)});
  assign negd_x = -diff_x;
  assign negd_y = -diff_y;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid && keep;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload of the front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: magnitude and sign of the offset
      absd_x_r      <= diff_x[DW] ? negd_x[DW-1:0] : diff_x[DW-1:0];
      absd_y_r      <= diff_y[DW] ? negd_y[DW-1:0] : diff_y[DW-1:0];
      neg_x1_r      <= diff_x[DW];
      neg_y1_r      <= diff_y[DW];
      d1_r          <= d;
      side1_r.point_z <= DEPTH_W'(d);
      side1_r.red   <= in_data.red_in;
      side1_r.green <= in_data.green_in;
      side1_r.blue  <= in_data.blue_in;

      // Stage 2: offset times depth
      prod_x_r <= PW'(absd_x_r) * PW'(d1_r);
      prod_y_r <= PW'(absd_y_r) * PW'(d1_r);
      neg_x2_r <= neg_x1_r;
      neg_y2_r <= neg_y1_r;
      side2_r  <= side1_r;

      // Stage 3: numerator 32 * product + focal for round half away from zero
      num_x_r <= (NUM_W'(prod_x_r) << 5) + NUM_W'(focal_x);
      num_y_r <= (NUM_W'(prod_y_r) << 5) + NUM_W'(focal_y);
      flags_x_r.neg      <= neg_x2_r;
      flags_x_r.den_zero <= (focal_x == '0);
      flags_x_r.num_zero <= (prod_x_r == '0);
      flags_y_r.neg      <= neg_y2_r;
      flags_y_r.den_zero <= (focal_y == '0);
      flags_y_r.num_zero <= (prod_y_r == '0);
      side3_r <= side2_r;
    end
  end

  assign fr_valid = v3_r;
  assign num_x    = num_x_r;
  assign num_y    = num_y_r;
  assign flags_x  = flags_x_r;
  assign flags_y  = flags_y_r;
  assign fr_side  = side3_r;

endmodule

`default_nettype wire

>>> rtl/core/dpb_div_pipe.sv
// Two-lane restoring divider, one quotient bit per stage, with saturation at the end.
`default_nettype none

module dpb_div_pipe
  import dpb_pkg::*;
#(
  parameter int NUM_W = 38
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_v,
  input  wire logic [NUM_W-1:0]   num_x,
  input  wire logic [NUM_W-1:0]   num_y,
  input  wire logic [CFG_W:0]     den_x,
  input  wire logic [CFG_W:0]     den_y,
  input  wire axis_flags_t        flags_x,
  input  wire axis_flags_t        flags_y,
  input  wire side_t              side_in,
  output logic                    out_v,
  output out_point_t              out_point
);

  localparam int LANES = 2;

  logic [NUM_W-1:0] num_a   [0:LANES-1];
  logic [CFG_W:0]   den_a   [0:LANES-1];
  axis_flags_t      flg_a   [0:LANES-1];

  logic [NUM_W-1:0] rem_r   [0:LANES-1][0:QUO_W-1];
  logic [QUO_W-1:0] quo_r   [0:LANES-1][0:QUO_W-1];
  axis_flags_t      flg_r   [0:LANES-1][0:QUO_W-1];
  logic             v_r     [0:QUO_W-1];
  side_t            side_r  [0:QUO_W-1];

  assign num_a[0] = num_x;
  assign num_a[1] = num_y;
  assign den_a[0] = den_x;
  assign den_a[1] = den_y;
  assign flg_a[0] = flags_x;
  assign flg_a[1] = flags_y;

  // Sign and saturate one coordinate
  function automatic logic [PT_W-1:0] sat_axis(input logic [QUO_W-1:0] q,
                                               input axis_flags_t f);
    logic            sat_pos;
    logic            sat_neg;
    logic [PT_W-1:0] res;
    sat_pos = q[QUO_W-1] | q[QUO_W-2];
    sat_neg = q[QUO_W-1] | (q[QUO_W-2] & (|q[QUO_W-3:0]));
    if (f.den_zero) begin
      res = f.num_zero ? '0 : (f.neg ? PT_MIN : PT_MAX);
    end else if (f.neg) begin
      res = sat_neg ? PT_MIN : (PT_W'(0) - q[PT_W-1:0]);
    end else begin
      res = sat_pos ? PT_MAX : q[PT_W-1:0];
    end
    return res;
  endfunction

  // Valid bits and side fields move with the quotient stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QUO_W; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int s = 1; s < QUO_W; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int s = 1; s < QUO_W; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Quotient stages: stage s decides bit QUO_W-1-s
  for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;
      axis_flags_t      flg_in;
      logic             ge;

      if (s == 0) begin : g_first
        assign rem_in = num_a[ln];
        assign quo_in = '0;
        assign flg_in = flg_a[ln];
      end else begin : g_next
        assign rem_in = rem_r[ln][s-1];
        assign quo_in = quo_r[ln][s-1];
        assign flg_in = flg_r[ln][s-1];
      end

      assign ge = (rem_in >> K) >= NUM_W'(den_a[ln]);

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[ln][s] <= ge ? (rem_in - (NUM_W'(den_a[ln]) << K)) : rem_in;
          quo_r[ln][s] <= {quo_in[QUO_W-2:0], ge};
          flg_r[ln][s] <= flg_in;
        end
      end
    end
  end

  // Assemble the finished point
  assign out_v               = v_r[QUO_W-1];
  assign out_point.point_x   = $signed(sat_axis(quo_r[0][QUO_W-1], flg_r[0][QUO_W-1]));
  assign out_point.point_y   = $signed(sat_axis(quo_r[1][QUO_W-1], flg_r[1][QUO_W-1]));
  assign out_point.point_z   = side_r[QUO_W-1].point_z;
  assign out_point.red_out   = side_r[QUO_W-1].red;
  assign out_point.green_out = side_r[QUO_W-1].green;
  assign out_point.blue_out  = side_r[QUO_W-1].blue;

endmodule

`default_nettype wire

>>> rtl/core/dpb_out_skid.sv
// Output register with a skid entry; its fill state gates the pipeline advance.
`default_nettype none

module dpb_out_skid
  import dpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       pipe_v,
  input  wire out_point_t pipe_data,
  output logic            adv,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_point_t      out_data
);

  logic       out_v_r;
  logic       out_v_nxt;
  logic       skid_v_r;
  logic       skid_v_nxt;
  out_point_t out_d_r;
  out_point_t out_d_nxt;
  out_point_t skid_d_r;
  out_point_t skid_d_nxt;

  // Advance the pipeline only while the skid entry is free
  assign adv = !skid_v_r;

  // Drain the skid entry first, otherwise take the pipeline transaction
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (out_ready) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_v) begin
      if (!out_v_r || out_ready) begin
        out_d_nxt = pipe_data;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = pipe_data;
        skid_v_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

`default_nettype wire

>>> rtl/core/dpb_checker.sv
// Port-level checker for the back-projection top level and its bind.
`default_nettype none

module dpb_checker
  import dpb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire out_point_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // Refuse input only while a result is waiting
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused with no result waiting");

  // Empty the pipeline on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Drop pixels without a depth reading
  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.point_z != '0)
    else $error("result with zero depth");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
